// File: src/assert_macros.svh
// Assertion macros shared by the distance core RTL.
// Depends on nothing; include after the timescale line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the square root step for the distance core.
// Depends on nothing.
package bcd_pkg;

    localparam int CoordW       = 32;
    localparam int MagW         = 15;
    localparam int SumW         = 2 * MagW;
    localparam int RemW         = MagW + 2;
    localparam int BitsPerStage = 3;
    localparam int RootStages   = MagW / BitsPerStage;

    localparam logic [MagW-1:0] DistMax = '1;

    typedef struct packed {
        logic valid;
        logic zero;
        logic clamp;
    } t_ctl;

    typedef struct packed {
        logic [RemW-1:0] rem;
        logic [MagW-1:0] root;
        logic [SumW-1:0] x;
    } t_root_st;

    // One restoring digit: bring down the next bit pair and try root*4+1.
    function automatic t_root_st root_step(t_root_st s);
        t_root_st        o;
        logic [RemW-1:0] acc;
        logic [RemW-1:0] trial;
        acc   = {s.rem[RemW-3:0], s.x[SumW-1:SumW-2]};
        trial = {s.root, 2'b01};
        o.x   = {s.x[SumW-3:0], 2'b00};
        if (acc >= trial) begin
            o.rem  = acc - trial;
            o.root = {s.root[MagW-2:0], 1'b1};
        end else begin
            o.rem  = acc;
            o.root = {s.root[MagW-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// File: src/bcd_axis.sv
`timescale 1ns / 1ps
// One axis: box centre, offset magnitude and its square, three register stages.
// Depends on bcd_pkg.
module bcd_axis (
    input  logic                        i_clk,
    input  logic [bcd_pkg::CoordW-1:0]  i_lo,
    input  logic [bcd_pkg::CoordW-1:0]  i_hi,
    input  logic [bcd_pkg::CoordW-1:0]  i_pt,
    output logic [bcd_pkg::SumW-1:0]    o_sq,
    output logic                        o_big
);
    import bcd_pkg::*;

    logic [CoordW:0]   w_pair;
    logic [CoordW:0]   w_half;
    logic [CoordW-1:0] r_centre;
    logic [CoordW-1:0] r_pt;
    logic [CoordW:0]   w_diff;
    logic [CoordW:0]   w_abs;
    logic [MagW-1:0]   r_mag;
    logic              r_big_b;
    logic [SumW-1:0]   r_sq;
    logic              r_big_c;

    // Sign-extended sum, nudged up by one when negative so the halving truncates toward zero.
    assign w_pair = {i_lo[CoordW-1], i_lo} + {i_hi[CoordW-1], i_hi};
    assign w_half = w_pair + {{CoordW{1'b0}}, w_pair[CoordW]};

    assign w_diff = {r_pt[CoordW-1], r_pt} - {r_centre[CoordW-1], r_centre};
    assign w_abs  = w_diff[CoordW] ? (~w_diff + 1'b1) : w_diff;

    always_ff @(posedge i_clk) begin
        r_centre <= w_half[CoordW:1];
        r_pt     <= i_pt;
        r_mag    <= w_abs[MagW-1:0];
        r_big_b  <= |w_abs[CoordW-1:MagW];
        r_sq     <= SumW'(r_mag) * SumW'(r_mag);
        r_big_c  <= r_big_b;
    end

    assign o_sq  = r_sq;
    assign o_big = r_big_c;

endmodule

// File: src/bcd_root.sv
`timescale 1ns / 1ps
// Pipelined floor square root of the 30-bit sum, three result bits per stage.
// Depends on bcd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bcd_root (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bcd_pkg::t_ctl             i_ctl,
    input  logic [bcd_pkg::SumW-1:0]  i_sum,
    output bcd_pkg::t_ctl             o_ctl,
    output logic [bcd_pkg::MagW-1:0]  o_root
);
    import bcd_pkg::*;

    t_root_st src   [RootStages];
    t_root_st n_st  [RootStages];
    t_root_st r_st  [RootStages];
    t_ctl     r_ctl [RootStages];
    logic     w_rem_ok;

    always_comb begin
        src[0] = '{rem: '0, root: '0, x: i_sum};
        for (int s = 1; s < RootStages; s++) begin
            src[s] = r_st[s-1];
        end
    end

    always_comb begin
        t_root_st w_st;
        for (int s = 0; s < RootStages; s++) begin
            w_st = src[s];
            for (int j = 0; j < BitsPerStage; j++) begin
                w_st = root_step(w_st);
            end
            n_st[s] = w_st;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < RootStages; s++) begin
            r_st[s] <= n_st[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < RootStages; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl[0] <= i_ctl;
            for (int s = 1; s < RootStages; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    assign o_ctl  = r_ctl[RootStages-1];
    assign o_root = r_st[RootStages-1].root;

    // A floor root leaves a remainder no larger than twice the root.
    assign w_rem_ok = r_st[RootStages-1].rem <= {1'b0, r_st[RootStages-1].root, 1'b0};

    `ASSERT_IMP(a_root_rem, i_clk, i_rst_n, o_ctl.valid && !o_ctl.clamp, w_rem_ok, "root remainder too large")

endmodule

// File: src/box_centre_distance_isqrt_core.sv
`timescale 1ns / 1ps
// Top level of the box centre distance core: axis units, sum stage, root pipeline.
// Depends on bcd_pkg, bcd_axis, bcd_root and assert_macros.svh.
`include "assert_macros.svh"
// Takes one box and point pair on every clock cycle and returns
// floor(sqrt(dx^2 + dy^2 + dz^2)) clamped to 32767, where each offset runs
// from the point to the box centre (min + max) / 2 truncated toward zero.
// The pipeline registers the per-axis arithmetic (centre, offset, square),
// then the sum and clamp decision, then the root stages for the 15-bit root
// at three bits per stage, and last one output register. busy stays low:
// the pipeline has no loop and nothing to wait for, and since the receiver
// cannot stall, each result is shown on o_distance for exactly the one cycle
// that o_valid marks, in the order the items came in. A cleared box_present
// gives a distance of zero.
module box_centre_distance_isqrt_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bcd_pkg::CoordW-1:0]    i_box_min_x,
    input  logic [bcd_pkg::CoordW-1:0]    i_box_min_y,
    input  logic [bcd_pkg::CoordW-1:0]    i_box_min_z,
    input  logic [bcd_pkg::CoordW-1:0]    i_box_max_x,
    input  logic [bcd_pkg::CoordW-1:0]    i_box_max_y,
    input  logic [bcd_pkg::CoordW-1:0]    i_box_max_z,
    input  logic [bcd_pkg::CoordW-1:0]    i_point_x,
    input  logic [bcd_pkg::CoordW-1:0]    i_point_y,
    input  logic [bcd_pkg::CoordW-1:0]    i_point_z,
    input  logic                          i_box_present,
    output logic                          o_valid,
    output logic [bcd_pkg::MagW-1:0]      o_distance
);
    import bcd_pkg::*;

    logic            w_accept;
    logic [SumW-1:0] w_sq_x, w_sq_y, w_sq_z;
    logic            w_big_x, w_big_y, w_big_z;

    // Control travelling alongside the axis stages.
    t_ctl r_ctl_a, r_ctl_b, r_ctl_c;
    t_ctl n_ctl_d, r_ctl_d;

    logic [SumW+1:0] w_sum;
    logic [SumW-1:0] r_sum;

    t_ctl            w_root_ctl;
    logic [MagW-1:0] w_root;

    logic            n_valid, r_valid;
    logic [MagW-1:0] n_distance, r_distance;

    logic            w_out_zero;
    logic            w_out_clamp;

    // Never hold off a transfer: one item enters on every cycle.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    bcd_axis u_axis_x (
        .i_clk (i_clk),
        .i_lo  (i_box_min_x),
        .i_hi  (i_box_max_x),
        .i_pt  (i_point_x),
        .o_sq  (w_sq_x),
        .o_big (w_big_x)
    );

    bcd_axis u_axis_y (
        .i_clk (i_clk),
        .i_lo  (i_box_min_y),
        .i_hi  (i_box_max_y),
        .i_pt  (i_point_y),
        .o_sq  (w_sq_y),
        .o_big (w_big_y)
    );

    bcd_axis u_axis_z (
        .i_clk (i_clk),
        .i_lo  (i_box_min_z),
        .i_hi  (i_box_max_z),
        .i_pt  (i_point_z),
        .o_sq  (w_sq_z),
        .o_big (w_big_z)
    );

    // Three squares below 2^30 each fit in 32 bits. Clamp when any offset
    // reaches 32768 or the sum reaches 2^30: either way the root is 32768 or
    // more, so the root never needs the upper bits of the wide sum.
    assign w_sum = (SumW+2)'(w_sq_x) + (SumW+2)'(w_sq_y) + (SumW+2)'(w_sq_z);

    always_comb begin
        n_ctl_d       = r_ctl_c;
        n_ctl_d.clamp = w_big_x || w_big_y || w_big_z || (|w_sum[SumW+1:SumW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
            r_ctl_d <= '0;
        end else begin
            r_ctl_a <= '{valid: w_accept, zero: !i_box_present, clamp: 1'b0};
            r_ctl_b <= r_ctl_a;
            r_ctl_c <= r_ctl_b;
            r_ctl_d <= n_ctl_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= w_sum[SumW-1:0];
    end

    bcd_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl_d),
        .i_sum   (r_sum),
        .o_ctl   (w_root_ctl),
        .o_root  (w_root)
    );

    // Pick the result: a missing box wins over the clamp, the clamp over the root.
    always_comb begin
        n_valid = w_root_ctl.valid;
        if (w_root_ctl.zero) begin
            n_distance = '0;
        end else if (w_root_ctl.clamp) begin
            n_distance = DistMax;
        end else begin
            n_distance = w_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_distance <= n_distance;
    end

    assign o_valid    = r_valid;
    assign o_distance = r_distance;

    assign w_out_zero  = w_root_ctl.valid && w_root_ctl.zero;
    assign w_out_clamp = w_root_ctl.valid && w_root_ctl.clamp && !w_root_ctl.zero;

    `ASSERT_NXT(a_out_follows, i_clk, i_rst_n, w_root_ctl.valid, o_valid, "result strobe lost")
    `ASSERT_NXT(a_zero_box, i_clk, i_rst_n, w_out_zero, o_distance == '0, "missing box gave a distance")
    `ASSERT_NXT(a_clamp_out, i_clk, i_rst_n, w_out_clamp, o_distance == DistMax, "clamped distance wrong")

endmodule
